### src/bbc_pkg.sv
// Shared constants and codes for the block buffer cache controller.
`timescale 1ns / 1ps
package bbc_pkg;
    localparam int NUM_BUFFERS = 16;
    localparam int BLOCK_BITS  = 32;
    localparam int SLOT_W      = $clog2(NUM_BUFFERS);
    localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SYNC  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] KIND_READY = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_WBACK = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LOOKUP = 8'b0000_0010,
        ST_VICTIM = 8'b0000_0100,
        ST_FL_RD  = 8'b0000_1000,
        ST_FL_EM  = 8'b0001_0000,
        ST_FINAL  = 8'b0010_0000,
        ST_QUEUE  = 8'b0100_0000,
        ST_RECENT = 8'b1000_0000
    } t_state;
endpackage

### src/block_buffer_cache_controller.sv
// Top level of the block buffer cache controller: tag memory, flags and sequencer.
`timescale 1ns / 1ps
// A request (read, write or sync) is taken while start is high and busy is low;
// results then appear one per strobe and cannot be held off. The length of a
// request is set by the single read port of the tag memory and the walks that
// visit one entry at a time. A read or write hit takes a tag scan plus a
// recency update. A miss adds a victim search. When every buffer is dirty,
// forced write-backs of each queued dirty buffer are added, and a step to end
// the walk. A write adds a write-back queue update. A sync writes back each
// queued dirty buffer and ends with a done result. An opcode of three is
// dropped.
module block_buffer_cache_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [bbc_pkg::BLOCK_BITS-1:0] i_block_number,
    output logic                          o_strobe,
    output logic [1:0]                    o_kind,
    output logic [bbc_pkg::SLOT_W-1:0]    o_slot,
    output logic [bbc_pkg::BLOCK_BITS-1:0] o_block_number_out,
    output logic                          o_last
);
    import bbc_pkg::*;

    t_state r_state;

    // Tag memory, one read and one write port, registered read data.
    logic [BLOCK_BITS-1:0] r_tag_mem [NUM_BUFFERS];
    logic [BLOCK_BITS-1:0] r_tag_rd;
    logic [SLOT_W-1:0]     tag_rd_addr;
    logic                  tag_we;
    logic [SLOT_W-1:0]     tag_wr_addr;

    // Per-slot flags, recency list and write-back queue.
    logic [NUM_BUFFERS-1:0] r_unused, r_valid, r_dirty;
    logic [SLOT_W-1:0]      r_rec   [NUM_BUFFERS];
    logic [SLOT_W-1:0]      r_queue [NUM_BUFFERS];
    logic [CNT_W-1:0]       r_count;

    // Request context.
    logic [1:0]            r_op;
    logic [BLOCK_BITS-1:0] r_blk;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W-1:0]     r_idx;
    logic                  r_cmp_v;
    logic [SLOT_W-1:0]     r_cmp_slot;
    logic [SLOT_W-1:0]     r_p;
    logic [CNT_W-1:0]      r_qi;
    logic [SLOT_W-1:0]     r_fs;
    logic                  r_found;
    logic                  r_sync;

    // Result register.
    logic                  r_strobe;
    logic [1:0]            r_kind;
    logic [SLOT_W-1:0]     r_oslot;
    logic [BLOCK_BITS-1:0] r_oblk;
    logic                  r_last;

    logic [SLOT_W-1:0] vic_slot;
    logic [SLOT_W-1:0] lru_slot;
    logic [SLOT_W-1:0] qi_idx;
    logic [CNT_W-1:0]  count_m1;
    logic              q_found_now;
    logic              r_found_now;

    assign busy               = (r_state != ST_IDLE);
    assign o_strobe           = r_strobe;
    assign o_kind             = r_kind;
    assign o_slot             = r_oslot;
    assign o_block_number_out = r_oblk;
    assign o_last             = r_last;

    assign vic_slot    = r_rec[r_p];
    assign lru_slot    = r_rec[SLOT_W'(NUM_BUFFERS - 1)];
    assign qi_idx      = r_qi[SLOT_W-1:0];
    assign count_m1    = CNT_W'(r_count - 1'b1);
    assign q_found_now = r_found || (r_queue[qi_idx] == r_slot);
    assign r_found_now = r_found || (r_rec[r_p] == r_slot);

    // Tag memory address and retag write selection.
    always_comb begin
        tag_rd_addr = r_idx;
        tag_we      = 1'b0;
        tag_wr_addr = vic_slot;
        case (r_state)
            ST_LOOKUP: begin
                tag_rd_addr = r_idx;
            end
            ST_VICTIM: begin
                tag_we      = !r_dirty[vic_slot] || r_unused[vic_slot];
                tag_wr_addr = vic_slot;
            end
            ST_FL_RD: begin
                tag_rd_addr = r_queue[qi_idx];
                tag_we      = (r_qi >= r_count) && !r_sync;
                tag_wr_addr = lru_slot;
            end
            default: begin
                tag_rd_addr = r_idx;
            end
        endcase
    end

    // Tag memory.
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_wr_addr] <= r_blk;
        end
        r_tag_rd <= r_tag_mem[tag_rd_addr];
    end

    // Sequencer and state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_unused <= '1;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_cmp_v  <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_rec[i] <= SLOT_W'(i);
            end
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_op    <= i_opcode;
                        r_blk   <= i_block_number;
                        r_idx   <= '0;
                        r_cmp_v <= 1'b0;
                        r_qi    <= '0;
                        if (i_opcode == OP_SYNC) begin
                            r_sync  <= 1'b1;
                            r_state <= ST_FL_RD;
                        end else if (i_opcode != OP_NONE) begin
                            r_sync  <= 1'b0;
                            r_state <= ST_LOOKUP;
                        end
                    end
                end
                // Tag scan: one read issued per cycle, compared the next.
                ST_LOOKUP: begin
                    r_idx      <= r_idx + 1'b1;
                    r_cmp_v    <= 1'b1;
                    r_cmp_slot <= r_idx;
                    if (r_cmp_v && !r_unused[r_cmp_slot] && r_tag_rd == r_blk) begin
                        r_slot  <= r_cmp_slot;
                        r_state <= ST_FINAL;
                    end else if (r_cmp_v && r_cmp_slot == SLOT_W'(NUM_BUFFERS - 1)) begin
                        r_p     <= SLOT_W'(NUM_BUFFERS - 1);
                        r_state <= ST_VICTIM;
                    end
                end
                // Victim search from least recently used upward.
                ST_VICTIM: begin
                    if (!r_dirty[vic_slot] || r_unused[vic_slot]) begin
                        r_slot             <= vic_slot;
                        r_unused[vic_slot] <= 1'b0;
                        r_valid[vic_slot]  <= 1'b0;
                        r_dirty[vic_slot]  <= 1'b0;
                        r_state            <= ST_FINAL;
                    end else if (r_p == '0) begin
                        r_qi    <= '0;
                        r_state <= ST_FL_RD;
                    end else begin
                        r_p <= r_p - 1'b1;
                    end
                end
                // Write-back walk: fetch the tag of the next queued slot.
                ST_FL_RD: begin
                    if (r_qi >= r_count) begin
                        r_count <= '0;
                        if (r_sync) begin
                            r_strobe <= 1'b1;
                            r_kind   <= KIND_DONE;
                            r_oslot  <= '0;
                            r_oblk   <= '0;
                            r_last   <= 1'b1;
                            r_state  <= ST_IDLE;
                        end else begin
                            // After the flush every buffer is clean.
                            r_slot             <= lru_slot;
                            r_unused[lru_slot] <= 1'b0;
                            r_valid[lru_slot]  <= 1'b0;
                            r_dirty[lru_slot]  <= 1'b0;
                            r_state            <= ST_FINAL;
                        end
                    end else begin
                        r_fs    <= r_queue[qi_idx];
                        r_state <= ST_FL_EM;
                    end
                end
                ST_FL_EM: begin
                    if (r_dirty[r_fs]) begin
                        r_strobe      <= 1'b1;
                        r_kind        <= KIND_WBACK;
                        r_oslot       <= r_fs;
                        r_oblk        <= r_tag_rd;
                        r_last        <= 1'b0;
                        r_dirty[r_fs] <= 1'b0;
                    end
                    r_qi    <= r_qi + 1'b1;
                    r_state <= ST_FL_RD;
                end
                // Final transfer of a read or write.
                ST_FINAL: begin
                    r_strobe <= 1'b1;
                    r_oslot  <= r_slot;
                    r_oblk   <= r_blk;
                    r_last   <= 1'b1;
                    r_valid[r_slot] <= 1'b1;
                    r_found  <= 1'b0;
                    r_qi     <= '0;
                    r_p      <= SLOT_W'(NUM_BUFFERS - 1);
                    if (r_op == OP_WRITE) begin
                        r_kind          <= KIND_READY;
                        r_dirty[r_slot] <= 1'b1;
                        r_state         <= ST_QUEUE;
                    end else begin
                        r_kind  <= r_valid[r_slot] ? KIND_READY : KIND_FILL;
                        r_state <= ST_RECENT;
                    end
                end
                // Move the slot to the tail of the write-back queue.
                ST_QUEUE: begin
                    if (r_count == '0) begin
                        r_queue[0] <= r_slot;
                        r_count    <= CNT_W'(1);
                        r_state    <= ST_RECENT;
                    end else if (r_qi == count_m1) begin
                        if (q_found_now) begin
                            r_queue[qi_idx] <= r_slot;
                        end else begin
                            r_queue[r_count[SLOT_W-1:0]] <= r_slot;
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= ST_RECENT;
                    end else begin
                        if (q_found_now) begin
                            r_queue[qi_idx] <= r_queue[qi_idx + 1'b1];
                        end
                        r_found <= q_found_now;
                        r_qi    <= r_qi + 1'b1;
                    end
                    if (r_count == '0 || r_qi == count_m1) begin
                        r_found <= 1'b0;
                    end
                end
                // Move the slot to the most recent position, top down.
                ST_RECENT: begin
                    if (r_p == '0) begin
                        r_rec[0] <= r_slot;
                        r_state  <= ST_IDLE;
                    end else begin
                        if (r_found_now) begin
                            r_rec[r_p] <= r_rec[r_p - 1'b1];
                        end
                        r_found <= r_found_now;
                        r_p     <= r_p - 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
